>>> design/dedge_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and types of the depth edge detector.
package dedge_pkg;

    localparam int DEPTH_BITS     = 16;
    localparam int COORD_W        = 10;
    localparam int SIZE_W         = 11;
    localparam int STRIDE_W       = 7;
    localparam int LIMIT_W        = 16;
    localparam int GAIN_W         = 16;
    localparam int FRAC_BITS      = 12;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_STRIDE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR_LIMIT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_GAIN     = 3'd5;

    localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST   = 11'd640;
    localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST  = 11'd480;
    localparam logic [STRIDE_W-1:0] SAMPLE_STRIDE_RST = 7'd1;
    localparam logic [LIMIT_W-1:0]  NEAR_LIMIT_RST    = 16'd0;
    localparam logic [LIMIT_W-1:0]  FAR_LIMIT_RST     = 16'd65535;
    localparam logic [GAIN_W-1:0]   EDGE_GAIN_RST     = 16'd82;

    typedef struct packed {
        logic busy;
        logic sampled;
        logic row_end;
        logic frame_end;
    } phase_flags_t;

    typedef struct packed {
        logic load_prod;
        logic load_scale;
    } cmp_ctl_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               missing_mark;
        logic               range_reject_mark;
        logic               edge_here;
        logic               row_partner_mark;
        logic [COORD_W-1:0] row_partner_x;
        logic               col_partner_mark;
        logic [COORD_W-1:0] col_partner_y;
        logic               frame_end;
    } result_t;

endpackage

>>> design/dedge_if.sv
`timescale 1ns / 1ps
// Pixel input and result output channel interfaces of the depth edge detector.
interface dedge_in_if
    import dedge_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [DEPTH_BITS-1:0] depth_mm;
    logic                  depth_missing;

    modport source (output valid, output depth_mm, output depth_missing, input ready);
    modport sink (input valid, input depth_mm, input depth_missing, output ready);
endinterface

interface dedge_out_if
    import dedge_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               missing_mark;
    logic               range_reject_mark;
    logic               edge_here;
    logic               row_partner_mark;
    logic [COORD_W-1:0] row_partner_x;
    logic               col_partner_mark;
    logic [COORD_W-1:0] col_partner_y;
    logic               frame_end;

    modport source (
        output valid, output pixel_x, output pixel_y, output missing_mark,
        output range_reject_mark, output edge_here, output row_partner_mark,
        output row_partner_x, output col_partner_mark, output col_partner_y,
        output frame_end, input ready
    );
    modport sink (
        input valid, input pixel_x, input pixel_y, input missing_mark,
        input range_reject_mark, input edge_here, input row_partner_mark,
        input row_partner_x, input col_partner_mark, input col_partner_y,
        input frame_end, output ready
    );
endinterface

>>> design/dedge_cmp.sv
`timescale 1ns / 1ps
// Two-stage exact edge test: |a - b| * 4096 > gain * min(a, b) * span.
module dedge_cmp
    import dedge_pkg::*;
#(
    parameter int SPAN_W = 10
)(
    input  logic                  clk,
    input  cmp_ctl_t              ctl,
    input  logic [GAIN_W-1:0]     gain,
    input  logic [DEPTH_BITS-1:0] a,
    input  logic [DEPTH_BITS-1:0] b,
    input  logic [SPAN_W-1:0]     span,
    output logic                  hit
);

    localparam int PW   = GAIN_W + DEPTH_BITS;
    localparam int CMPW = PW + SPAN_W;

    logic [DEPTH_BITS-1:0] diff;
    logic [DEPTH_BITS-1:0] lo;
    logic [DEPTH_BITS-1:0] diff_reg;
    logic [PW-1:0]         prod_reg;
    logic [SPAN_W-1:0]     span_reg;
    logic [DEPTH_BITS-1:0] diff2_reg;
    logic [CMPW-1:0]       scale_reg;
    logic [CMPW-1:0]       lhs;

    assign diff = (a > b) ? (a - b) : (b - a);
    assign lo   = (a < b) ? a : b;

    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            diff_reg <= diff;
            prod_reg <= PW'(gain) * PW'(lo);
            span_reg <= span;
        end
        if (ctl.load_scale)
        begin
            diff2_reg <= diff_reg;
            scale_reg <= CMPW'(prod_reg) * CMPW'(span_reg);
        end
    end

    assign lhs = CMPW'(diff2_reg) << FRAC_BITS;
    assign hit = lhs > scale_reg;

endmodule

>>> design/dedge_phase.sv
`timescale 1ns / 1ps
// Column and row counters with sample-stride phases and a bit-serial phase resync.
module dedge_phase
    import dedge_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SIZE_W-1:0]   frame_width,
    input  logic [SIZE_W-1:0]   frame_height,
    input  logic [STRIDE_W-1:0] sample_stride,
    input  logic                stride_write,
    input  logic                advance,
    output logic [XW-1:0]       x,
    output logic [YW-1:0]       y,
    output phase_flags_t        flags
);

    localparam int CW  = (XW > YW) ? XW : YW;
    localparam int BW  = $clog2(CW);
    localparam int WCW = ((XW + 1) > SIZE_W) ? (XW + 1) : SIZE_W;
    localparam int HCW = ((YW + 1) > SIZE_W) ? (YW + 1) : SIZE_W;

    logic [XW-1:0]       x_reg, x_next;
    logic [YW-1:0]       y_reg, y_next;
    logic [STRIDE_W-1:0] cphase_reg, cphase_next;
    logic [STRIDE_W-1:0] rphase_reg, rphase_next;
    logic                busy_reg, busy_next;
    logic [BW-1:0]       pos_reg, pos_next;
    logic [STRIDE_W-1:0] remx_reg, remx_next;
    logic [STRIDE_W-1:0] remy_reg, remy_next;

    logic [WCW-1:0]      w_eff;
    logic [HCW-1:0]      h_eff;
    logic [STRIDE_W-1:0] s_eff;
    logic                row_end;
    logic                frame_end;
    logic [CW-1:0]       x_ext;
    logic [CW-1:0]       y_ext;
    logic [STRIDE_W-1:0] remx_step;
    logic [STRIDE_W-1:0] remy_step;
    logic [STRIDE_W-1:0] cphase_inc;
    logic [STRIDE_W-1:0] rphase_inc;
    logic [STRIDE_W-1:0] cphase_wrap;
    logic [STRIDE_W-1:0] rphase_wrap;

    function automatic logic [STRIDE_W-1:0] rem_step(
        input logic [STRIDE_W-1:0] rem,
        input logic                bit_in,
        input logic [STRIDE_W-1:0] s
    );
        logic [STRIDE_W:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, s})
        begin
            trial = trial - {1'b0, s};
        end
        return trial[STRIDE_W-1:0];
    endfunction

    always_comb
    begin
        w_eff = WCW'(frame_width);
        if (frame_width == '0)
        begin
            w_eff = WCW'(1);
        end
        else if (WCW'(frame_width) > WCW'(MAX_WIDTH))
        begin
            w_eff = WCW'(MAX_WIDTH);
        end
        h_eff = HCW'(frame_height);
        if (frame_height == '0)
        begin
            h_eff = HCW'(1);
        end
        else if (HCW'(frame_height) > HCW'(MAX_HEIGHT))
        begin
            h_eff = HCW'(MAX_HEIGHT);
        end
    end

    assign s_eff     = (sample_stride == '0) ? STRIDE_W'(1) : sample_stride;
    assign row_end   = (WCW'(x_reg) + WCW'(1)) >= w_eff;
    assign frame_end = row_end && ((HCW'(y_reg) + HCW'(1)) >= h_eff);

    assign x_ext     = CW'(x_reg);
    assign y_ext     = CW'(y_reg);
    assign remx_step = rem_step(remx_reg, x_ext[pos_reg], s_eff);
    assign remy_step = rem_step(remy_reg, y_ext[pos_reg], s_eff);

    assign cphase_inc  = cphase_reg + STRIDE_W'(1);
    assign rphase_inc  = rphase_reg + STRIDE_W'(1);
    assign cphase_wrap = (cphase_inc >= s_eff) ? '0 : cphase_inc;
    assign rphase_wrap = (rphase_inc >= s_eff) ? '0 : rphase_inc;

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        cphase_next = cphase_reg;
        rphase_next = rphase_reg;
        busy_next   = busy_reg;
        pos_next    = pos_reg;
        remx_next   = remx_reg;
        remy_next   = remy_reg;
        if (stride_write)
        begin
            busy_next = 1'b1;
            pos_next  = BW'(CW - 1);
            remx_next = '0;
            remy_next = '0;
        end
        else if (busy_reg)
        begin
            remx_next = remx_step;
            remy_next = remy_step;
            pos_next  = pos_reg - BW'(1);
            if (pos_reg == '0)
            begin
                busy_next   = 1'b0;
                cphase_next = remx_step;
                rphase_next = remy_step;
            end
        end
        else if (advance)
        begin
            if (row_end)
            begin
                x_next      = '0;
                cphase_next = '0;
                if (frame_end)
                begin
                    y_next      = '0;
                    rphase_next = '0;
                end
                else
                begin
                    y_next      = y_reg + YW'(1);
                    rphase_next = rphase_wrap;
                end
            end
            else
            begin
                x_next      = x_reg + XW'(1);
                cphase_next = cphase_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            cphase_reg <= '0;
            rphase_reg <= '0;
            busy_reg   <= 1'b0;
            pos_reg    <= '0;
            remx_reg   <= '0;
            remy_reg   <= '0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            cphase_reg <= cphase_next;
            rphase_reg <= rphase_next;
            busy_reg   <= busy_next;
            pos_reg    <= pos_next;
            remx_reg   <= remx_next;
            remy_reg   <= remy_next;
        end
    end

    assign x               = x_reg;
    assign y               = y_reg;
    assign flags.busy      = busy_reg;
    assign flags.sampled   = (cphase_reg == '0) && (rphase_reg == '0);
    assign flags.row_end   = row_end;
    assign flags.frame_end = frame_end;

endmodule

>>> design/depth_edge_detection.sv
`timescale 1ns / 1ps
// Depth edge detector top level: takes one depth pixel per transaction in raster order,
// counts column and row itself and returns one result per pixel with missing and range
// flags and the row and column edge tests against the previous valid sampled pixel.
// A pixel passes through accept, column store read, gain multiply, distance multiply and
// compare with write-back. The column store is one synchronous memory of MAX_WIDTH
// entries, read for every pixel and rewritten only for sampled pixels that are valid or
// in row 0; the next pixel is accepted only after the write-back, so same-column accesses
// never overlap. A result waits in an output register while the next pixel is taken.
// A write to sample_stride starts a bit-serial phase resync during which no pixel is
// accepted. The column store has no clearing pass: row 0 of every frame writes each
// sampled column before later rows read it.
module depth_edge_detection
    import dedge_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    dedge_in_if.sink               pixels,
    dedge_out_if.source            results
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int EW = 1 + YW + DEPTH_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_CMP  = 2'd3;

    logic [SIZE_W-1:0]     frame_width_reg;
    logic [SIZE_W-1:0]     frame_height_reg;
    logic [STRIDE_W-1:0]   sample_stride_reg;
    logic [LIMIT_W-1:0]    near_limit_reg;
    logic [LIMIT_W-1:0]    far_limit_reg;
    logic [GAIN_W-1:0]     edge_gain_reg;

    logic [1:0]            state_reg, state_next;
    logic [DEPTH_BITS-1:0] d_reg;
    logic                  missing_reg;
    logic                  rp_valid_reg;
    logic [XW-1:0]         rp_x_reg;
    logic [DEPTH_BITS-1:0] rp_depth_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               result_reg, result_next;

    logic [EW-1:0]         col_mem [MAX_WIDTH];
    logic [EW-1:0]         col_rd_reg;
    logic                  mem_we;
    logic [EW-1:0]         mem_wdata;

    logic [XW-1:0]         x;
    logic [YW-1:0]         y;
    phase_flags_t          flags;
    logic                  stride_write;
    logic                  accept;
    logic                  complete;
    logic                  reject;
    logic                  valid_px;
    logic                  e_valid;
    logic [YW-1:0]         e_row;
    logic [DEPTH_BITS-1:0] e_depth;
    cmp_ctl_t              cmp_ctl;
    logic                  row_hit;
    logic                  col_hit;
    logic                  row_edge;
    logic                  col_edge;
    logic                  sample_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            sample_stride_reg <= SAMPLE_STRIDE_RST;
            near_limit_reg    <= NEAR_LIMIT_RST;
            far_limit_reg     <= FAR_LIMIT_RST;
            edge_gain_reg     <= EDGE_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SAMPLE_STRIDE: sample_stride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_NEAR_LIMIT:    near_limit_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_FAR_LIMIT:     far_limit_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_EDGE_GAIN:     edge_gain_reg     <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign stride_write = cfg_we && (cfg_index == CFG_SAMPLE_STRIDE);

    dedge_phase #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .sample_stride (sample_stride_reg),
        .stride_write  (stride_write),
        .advance       (complete),
        .x             (x),
        .y             (y),
        .flags         (flags)
    );

    assign pixels.ready = (state_reg == S_IDLE) && !flags.busy;
    assign accept       = pixels.valid && pixels.ready;
    assign complete     = (state_reg == S_CMP) && (!out_valid_reg || results.ready);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg       <= pixels.depth_mm;
            missing_reg <= pixels.depth_missing;
        end
    end

    assign reject   = !missing_reg && ((d_reg >= far_limit_reg) || (d_reg <= near_limit_reg));
    assign valid_px = !missing_reg && !reject;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            col_mem[x] <= mem_wdata;
        end
        col_rd_reg <= col_mem[x];
    end

    assign e_valid = col_rd_reg[EW-1];
    assign e_row   = col_rd_reg[EW-2 -: YW];
    assign e_depth = col_rd_reg[DEPTH_BITS-1:0];

    assign cmp_ctl.load_prod  = (state_reg == S_READ);
    assign cmp_ctl.load_scale = (state_reg == S_MUL);

    dedge_cmp #(
        .SPAN_W (XW)
    ) u_row_cmp (
        .clk  (clk),
        .ctl  (cmp_ctl),
        .gain (edge_gain_reg),
        .a    (d_reg),
        .b    (rp_depth_reg),
        .span (x - rp_x_reg),
        .hit  (row_hit)
    );

    dedge_cmp #(
        .SPAN_W (YW)
    ) u_col_cmp (
        .clk  (clk),
        .ctl  (cmp_ctl),
        .gain (edge_gain_reg),
        .a    (d_reg),
        .b    (e_depth),
        .span (y - e_row),
        .hit  (col_hit)
    );

    assign sample_valid = flags.sampled && valid_px;
    assign row_edge = sample_valid && rp_valid_reg && (x != '0) && (rp_x_reg < x) && row_hit;
    assign col_edge = sample_valid && (y != '0) && e_valid && (e_row < y) && col_hit;

    assign mem_we    = complete && flags.sampled && (valid_px || (y == '0));
    assign mem_wdata = valid_px ? {1'b1, y, d_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_valid_reg <= 1'b0;
            rp_x_reg     <= '0;
            rp_depth_reg <= '0;
        end
        else if (complete)
        begin
            if (sample_valid)
            begin
                rp_valid_reg <= 1'b1;
                rp_x_reg     <= x;
                rp_depth_reg <= d_reg;
            end
            else if (x == '0)
            begin
                rp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        result_next                   = result_reg;
        result_next.pixel_x           = COORD_W'(x);
        result_next.pixel_y           = COORD_W'(y);
        result_next.missing_mark      = missing_reg;
        result_next.range_reject_mark = reject;
        result_next.edge_here         = row_edge || col_edge;
        result_next.row_partner_mark  = row_edge;
        result_next.row_partner_x     = row_edge ? COORD_W'(rp_x_reg) : '0;
        result_next.col_partner_mark  = col_edge;
        result_next.col_partner_y     = col_edge ? COORD_W'(e_row) : '0;
        result_next.frame_end         = flags.frame_end;
    end

    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (complete)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_MUL;
            S_MUL:   state_next = S_CMP;
            S_CMP:
            begin
                if (complete)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.pixel_x           = result_reg.pixel_x;
    assign results.pixel_y           = result_reg.pixel_y;
    assign results.missing_mark      = result_reg.missing_mark;
    assign results.range_reject_mark = result_reg.range_reject_mark;
    assign results.edge_here         = result_reg.edge_here;
    assign results.row_partner_mark  = result_reg.row_partner_mark;
    assign results.row_partner_x     = result_reg.row_partner_x;
    assign results.col_partner_mark  = result_reg.col_partner_mark;
    assign results.col_partner_y     = result_reg.col_partner_y;
    assign results.frame_end         = result_reg.frame_end;

endmodule

>>> design/dedge_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the depth edge detector and its bind to the top level.
module dedge_checker
    import dedge_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COORD_W-1:0] pixel_x,
    input logic [COORD_W-1:0] pixel_y,
    input logic               missing_mark,
    input logic               range_reject_mark,
    input logic               edge_here,
    input logic               row_partner_mark,
    input logic [COORD_W-1:0] row_partner_x,
    input logic               col_partner_mark,
    input logic [COORD_W-1:0] col_partner_y,
    input logic               frame_end
);

    logic wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            wrap_reg <= frame_end;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> edge_here == (row_partner_mark || col_partner_mark))
        else $error("edge flag disagrees with partner marks");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && missing_mark |-> !range_reject_mark && !edge_here)
        else $error("missing pixel flagged as rejected or edge");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_partner_mark || row_partner_x == '0) &&
                      (col_partner_mark || col_partner_y == '0))
        else $error("partner coordinate set without mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wrap_reg |-> pixel_x == '0 && pixel_y == '0)
        else $error("frame does not start at the origin");

endmodule

bind depth_edge_detection dedge_checker u_dedge_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (results.valid),
    .out_ready         (results.ready),
    .pixel_x           (results.pixel_x),
    .pixel_y           (results.pixel_y),
    .missing_mark      (results.missing_mark),
    .range_reject_mark (results.range_reject_mark),
    .edge_here         (results.edge_here),
    .row_partner_mark  (results.row_partner_mark),
    .row_partner_x     (results.row_partner_x),
    .col_partner_mark  (results.col_partner_mark),
    .col_partner_y     (results.col_partner_y),
    .frame_end         (results.frame_end)
);

>>> test/depth_edge_detection_tb.sv
`timescale 1ns / 1ps
// Testbench of the depth edge detector: a directed table, then random frames checked by a predictor.
module depth_edge_detection_tb;
    import dedge_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE         = 12;
    localparam int RANDOM_ITEMS   = 380;
    localparam int EXTREME_ITEMS  = 40;
    localparam int STORE_DEPTH    = MAX_WIDTH_DEF;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  value;
        logic [DEPTH_BITS-1:0]  depth;
        logic                   missing;
        logic                   typed;
        result_t                exp;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dedge_in_if  pixels_if();
    dedge_out_if results_if();

    depth_edge_detection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels_if),
        .results   (results_if)
    );

    // predictor copy of the registers and the scan state
    logic [SIZE_W-1:0]     width_cfg;
    logic [SIZE_W-1:0]     height_cfg;
    logic [STRIDE_W-1:0]   stride_cfg;
    logic [LIMIT_W-1:0]    near_cfg;
    logic [LIMIT_W-1:0]    far_cfg;
    logic [GAIN_W-1:0]     gain_cfg;
    logic [COORD_W-1:0]    next_x;
    logic [COORD_W-1:0]    next_y;
    logic                  row_seen;
    logic [COORD_W-1:0]    row_last_x;
    logic [DEPTH_BITS-1:0] row_last_depth;
    logic                  col_seen [STORE_DEPTH];
    logic [COORD_W-1:0]    col_last_y [STORE_DEPTH];
    logic [DEPTH_BITS-1:0] col_last_depth [STORE_DEPTH];

    result_t     marks_due [$];
    stim_row_t   stim_rows [$];
    int          errors = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned stall_mode = 0;
    int unsigned surface = 1500;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic reset_predictor();
        width_cfg      = FRAME_WIDTH_RST;
        height_cfg     = FRAME_HEIGHT_RST;
        stride_cfg     = SAMPLE_STRIDE_RST;
        near_cfg       = NEAR_LIMIT_RST;
        far_cfg        = FAR_LIMIT_RST;
        gain_cfg       = EDGE_GAIN_RST;
        next_x         = '0;
        next_y         = '0;
        row_seen       = 1'b0;
        row_last_x     = '0;
        row_last_depth = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            col_seen[i]       = 1'b0;
            col_last_y[i]     = '0;
            col_last_depth[i] = '0;
        end
    endtask

    function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] raw);
        int unsigned v;
        v = raw[SIZE_W-1:0];
        if (v < 1)
        begin
            v = 1;
        end
        if (v > MAX_WIDTH_DEF)
        begin
            v = MAX_WIDTH_DEF;
        end
        return v;
    endfunction

    function automatic bit is_discontinuity(logic [DEPTH_BITS-1:0] a, logic [DEPTH_BITS-1:0] b,
                                            int unsigned span);
        longint unsigned diff, nearer, gain;
        diff   = (a > b) ? a - b : b - a;
        nearer = (a < b) ? a : b;
        gain   = gain_cfg;
        return (diff << FRAC_BITS) > gain * nearer * span;
    endfunction

    function automatic result_t mark_pixel(logic [DEPTH_BITS-1:0] depth, logic missing);
        int unsigned w, h, s, x, y;
        logic        reject, usable, sampled, row_end;
        result_t     r;
        w = clamp_size(CFG_DATA_W'(width_cfg));
        h = clamp_size(CFG_DATA_W'(height_cfg));
        s = (stride_cfg == 0) ? 1 : stride_cfg;
        x = next_x;
        y = next_y;
        r = '0;
        if (x == 0)
        begin
            row_seen = 1'b0;
        end
        reject  = !missing && (depth >= far_cfg || depth <= near_cfg);
        usable  = !missing && !reject;
        sampled = (x % s == 0) && (y % s == 0);
        if (sampled && usable)
        begin
            if (row_seen && row_last_x < x &&
                is_discontinuity(depth, row_last_depth, x - row_last_x))
            begin
                r.row_partner_mark = 1'b1;
                r.row_partner_x    = row_last_x;
            end
            if (y != 0 && col_seen[x] && col_last_y[x] < y &&
                is_discontinuity(depth, col_last_depth[x], y - col_last_y[x]))
            begin
                r.col_partner_mark = 1'b1;
                r.col_partner_y    = col_last_y[x];
            end
            row_seen          = 1'b1;
            row_last_x        = COORD_W'(x);
            row_last_depth    = depth;
            col_seen[x]       = 1'b1;
            col_last_y[x]     = COORD_W'(y);
            col_last_depth[x] = depth;
        end
        else if (sampled && y == 0)
        begin
            col_seen[x]       = 1'b0;
            col_last_y[x]     = '0;
            col_last_depth[x] = '0;
        end
        row_end             = (x + 1 >= w);
        r.pixel_x           = COORD_W'(x);
        r.pixel_y           = COORD_W'(y);
        r.missing_mark      = missing;
        r.range_reject_mark = reject;
        r.edge_here         = r.row_partner_mark | r.col_partner_mark;
        r.frame_end         = row_end && (y + 1 >= h);
        if (row_end)
        begin
            next_x = '0;
            next_y = r.frame_end ? '0 : COORD_W'(y + 1);
        end
        else
        begin
            next_x = COORD_W'(x + 1);
        end
        return r;
    endfunction

    function automatic result_t typed_mark(int x, int y, bit missing, bit reject,
                                           bit row_partner, int partner_x, bit frame_end);
        result_t r;
        r                   = '0;
        r.pixel_x           = COORD_W'(x);
        r.pixel_y           = COORD_W'(y);
        r.missing_mark      = missing;
        r.range_reject_mark = reject;
        r.edge_here         = row_partner;
        r.row_partner_mark  = row_partner;
        r.row_partner_x     = COORD_W'(partner_x);
        r.frame_end         = frame_end;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        stim_row_t r;
        r           = '0;
        r.kind      = ROW_REG;
        r.reg_index = idx;
        r.value     = value;
        return r;
    endfunction

    function automatic stim_row_t pixel_row(logic [DEPTH_BITS-1:0] depth, logic missing,
                                            logic typed, result_t exp);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_PIXEL;
        r.depth   = depth;
        r.missing = missing;
        r.typed   = typed;
        r.exp     = exp;
        return r;
    endfunction

    function automatic void add_row(stim_row_t r);
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_FRAME_WIDTH:   width_cfg  = value[SIZE_W-1:0];
            CFG_FRAME_HEIGHT:  height_cfg = value[SIZE_W-1:0];
            CFG_SAMPLE_STRIDE: stride_cfg = value[STRIDE_W-1:0];
            CFG_NEAR_LIMIT:    near_cfg   = value[LIMIT_W-1:0];
            CFG_FAR_LIMIT:     far_cfg    = value[LIMIT_W-1:0];
            CFG_EDGE_GAIN:     gain_cfg   = value[GAIN_W-1:0];
            default:           ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pause(int unsigned cycles);
        if (cycles > 0)
        begin
            pixels_if.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // hold the input until every pending result is out, then let the pipeline settle
    task automatic drain();
        pixels_if.valid <= 1'b0;
        while (marks_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_pixel(logic [DEPTH_BITS-1:0] depth, logic missing, logic typed,
                              result_t typed_res);
        result_t predicted;
        pixels_if.valid         <= 1'b1;
        pixels_if.depth_mm      <= depth;
        pixels_if.depth_missing <= missing;
        @(posedge clk);
        while (!pixels_if.ready) @(posedge clk);
        predicted = mark_pixel(depth, missing);
        marks_due.insert(marks_due.size(), typed ? typed_res : predicted);
    endtask

    function automatic logic [DEPTH_BITS:0] draw_pixel();
        int unsigned           pick, spread;
        logic [DEPTH_BITS-1:0] depth;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
        begin
            surface = $urandom_range(200, 12000);
        end
        spread = surface / 8;
        if (pick < 8)
        begin
            return {1'b1, DEPTH_BITS'($urandom)};
        end
        if (pick < 14)
        begin
            case (pick % 6)
                0:       depth = '0;
                1:       depth = '1;
                2:       depth = near_cfg;
                3:       depth = far_cfg;
                4:       depth = near_cfg + 1'b1;
                default: depth = far_cfg - 1'b1;
            endcase
            return {1'b0, depth};
        end
        if (pick < 40)
        begin
            return {1'b0, DEPTH_BITS'($urandom)};
        end
        depth = DEPTH_BITS'(surface - spread / 2 + $urandom_range(0, spread));
        return {1'b0, depth};
    endfunction

    task automatic offer_pixel();
        logic [DEPTH_BITS:0] px;
        if ($urandom_range(0, 149) == 0)
        begin
            drain();
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                pause($urandom_range(1, 6));
            end
        end
        burst_left--;
        px = draw_pixel();
        send_pixel(px[DEPTH_BITS-1:0], px[DEPTH_BITS], 1'b0, '0);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                                logic [CFG_DATA_W-1:0] s, logic [CFG_DATA_W-1:0] near,
                                logic [CFG_DATA_W-1:0] far, logic [CFG_DATA_W-1:0] gain);
        drain();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_SAMPLE_STRIDE, s);
        write_reg(CFG_NEAR_LIMIT, near);
        write_reg(CFG_FAR_LIMIT, far);
        write_reg(CFG_EDGE_GAIN, gain);
    endtask

    task automatic random_phase(bit hold_long, inout int sent);
        logic [CFG_DATA_W-1:0] w, h, s, near, far, gain;
        int unsigned           per_frame, frames;
        w = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 20));
        h = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 10));
        w = w | (CFG_DATA_W'($urandom) & 16'hF800);
        h = h | (CFG_DATA_W'($urandom) & 16'hF800);
        // a frame large enough to fill the block during the long hold-off
        if (hold_long)
        begin
            w = 16'd12;
            h = 16'd6;
        end
        case ($urandom_range(0, 7))
            0:       s = 16'd0;
            1, 2:    s = 16'd1;
            3:       s = 16'd2;
            4:       s = 16'd3;
            5:       s = 16'd4;
            6:       s = 16'd64;
            default: s = 16'd127;
        endcase
        s = s | (CFG_DATA_W'($urandom) & 16'hFF80);
        case ($urandom_range(0, 9))
            0:       near = 16'd0;
            1:       near = 16'hFFFF;
            2:       near = CFG_DATA_W'($urandom);
            default: near = CFG_DATA_W'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 9))
            0:       far = 16'd0;
            1:       far = 16'hFFFF;
            2:       far = CFG_DATA_W'($urandom);
            default: far = CFG_DATA_W'($urandom_range(8000, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       gain = 16'd0;
            1:       gain = 16'hFFFF;
            2:       gain = 16'd4096;
            3:       gain = CFG_DATA_W'($urandom);
            default: gain = CFG_DATA_W'($urandom_range(0, 8191));
        endcase
        program_regs(w, h, s, near, far, gain);
        per_frame = clamp_size(w) * clamp_size(h);
        frames = 120 / per_frame;
        if (frames < 1)
        begin
            frames = 1;
        end
        if (frames > 3)
        begin
            frames = 3;
        end
        frames     = $urandom_range(1, frames);
        gaps_on    = hold_long ? 1'b0 : ($urandom_range(0, 3) != 0);
        burst_left = 0;
        if (hold_long)
        begin
            long_hold_req = 1'b1;
        end
        repeat (frames * per_frame) offer_pixel();
        sent += frames * per_frame;
    endtask

    // result receiver: stall patterns chosen at random in turn, plus one long hold-off
    initial
    begin
        int unsigned tick;
        tick = 0;
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 64 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            if (long_hold_req)
            begin
                results_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       results_if.ready <= 1'b1;
                    1:       results_if.ready <= ($urandom_range(0, 2) != 0);
                    2:       results_if.ready <= (tick % 5 != 0);
                    default: results_if.ready <= ((tick / 8) % 2 == 0);
                endcase
            end
        end
    end

    task automatic check_field(string field, logic [COORD_W-1:0] got_v,
                               logic [COORD_W-1:0] want_v, result_t want);
        if (got_v !== want_v)
        begin
            report_mismatch($sformatf("pixel (%0d,%0d) %s: got %0d, expected %0d",
                                      want.pixel_x, want.pixel_y, field, got_v, want_v));
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (marks_due.size() == 0)
            begin
                report_mismatch($sformatf("result at (%0d,%0d) with no pixel pending",
                                          results_if.pixel_x, results_if.pixel_y));
            end
            else
            begin
                want = marks_due.pop_front();
                check_field("pixel_x", results_if.pixel_x, want.pixel_x, want);
                check_field("pixel_y", results_if.pixel_y, want.pixel_y, want);
                check_field("missing_mark", results_if.missing_mark, want.missing_mark, want);
                check_field("range_reject_mark", results_if.range_reject_mark,
                            want.range_reject_mark, want);
                check_field("edge_here", results_if.edge_here, want.edge_here, want);
                check_field("row_partner_mark", results_if.row_partner_mark,
                            want.row_partner_mark, want);
                check_field("row_partner_x", results_if.row_partner_x, want.row_partner_x, want);
                check_field("col_partner_mark", results_if.col_partner_mark,
                            want.col_partner_mark, want);
                check_field("col_partner_y", results_if.col_partner_y, want.col_partner_y, want);
                check_field("frame_end", results_if.frame_end, want.frame_end, want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (pixels_if.valid && pixels_if.ready) ||
            (results_if.valid && results_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("depth_edge_detection_tb failed");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        int        sent;
        int        phase;
        sent  = 0;
        phase = 0;
        reset_predictor();
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= '0;
        cfg_data                <= '0;
        pixels_if.valid         <= 1'b0;
        pixels_if.depth_mm      <= '0;
        pixels_if.depth_missing <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: near and far extremes, missing overrides range
        add_row(pixel_row(16'd0, 1'b0, 1'b1, typed_mark(0, 0, 0, 1, 0, 0, 0)));
        add_row(pixel_row(16'hFFFF, 1'b1, 1'b1, typed_mark(1, 0, 1, 0, 0, 0, 0)));
        add_row(pixel_row(16'hFFFF, 1'b0, 1'b1, typed_mark(2, 0, 0, 1, 0, 0, 0)));
        add_row(pixel_row(16'd1000, 1'b0, 1'b1, typed_mark(3, 0, 0, 0, 0, 0, 0)));
        // shrink the frame mid-row: the next pixel ends row and frame
        add_row(reg_row(CFG_FRAME_WIDTH, 16'd2));
        add_row(reg_row(CFG_FRAME_HEIGHT, 16'd1));
        add_row(pixel_row(16'd2000, 1'b0, 1'b1, typed_mark(4, 0, 0, 0, 1, 3, 1)));
        // 4x3 frame, unit gain: row and column edges, rejects, missing column entry
        add_row(reg_row(CFG_FRAME_WIDTH, 16'd4));
        add_row(reg_row(CFG_FRAME_HEIGHT, 16'd3));
        add_row(reg_row(CFG_SAMPLE_STRIDE, 16'd1));
        add_row(reg_row(CFG_NEAR_LIMIT, 16'd100));
        add_row(reg_row(CFG_FAR_LIMIT, 16'd60000));
        add_row(reg_row(CFG_EDGE_GAIN, 16'd4096));
        add_row(pixel_row(16'd1000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd1500, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd4000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd3000, 1'b1, 1'b0, '0));
        add_row(pixel_row(16'd1000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd100, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd5000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd60000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd3000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd2000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd12000, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd9000, 1'b0, 1'b0, '0));
        // 3x3 frame, stride 2, zero gain: equal depths never edge, distance two
        add_row(reg_row(CFG_FRAME_WIDTH, 16'd3));
        add_row(reg_row(CFG_SAMPLE_STRIDE, 16'd2));
        add_row(reg_row(CFG_NEAR_LIMIT, 16'd0));
        add_row(reg_row(CFG_FAR_LIMIT, 16'hFFFF));
        add_row(reg_row(CFG_EDGE_GAIN, 16'd0));
        add_row(pixel_row(16'd500, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd800, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd500, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd7, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd7, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd7, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd500, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd7, 1'b0, 1'b0, '0));
        add_row(pixel_row(16'd900, 1'b0, 1'b0, '0));

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_REG)
            begin
                drain();
                write_reg(row.reg_index, row.value);
            end
            else
            begin
                send_pixel(row.depth, row.missing, row.typed, row.exp);
            end
        end

        while (sent < RANDOM_ITEMS)
        begin
            random_phase(phase == 1, sent);
            phase++;
        end

        // widest frame, stride 64 and largest gain: the first columns of row 0
        gaps_on = 1'b1;
        program_regs(16'hFFFF, 16'hF800, 16'd64, 16'd0, 16'hFFFF, 16'hFFFF);
        repeat (EXTREME_ITEMS) offer_pixel();
        // tallest frame, one column: the shrink ends the current row at once
        program_regs(16'd0, 16'd1024, 16'hFF81, 16'd1, 16'hFFFE, 16'd2048);
        repeat (EXTREME_ITEMS) offer_pixel();

        drain();
        if (errors == 0)
        begin
            $display("depth_edge_detection_tb passed");
        end
        else
        begin
            $display("depth_edge_detection_tb failed");
        end
        $finish;
    end

endmodule
